// ===== hdl/masked_byte_pattern_scanner_core_defines.svh =====
// Assertion macros for the masked byte pattern scanner.
`ifndef MASKED_BYTE_PATTERN_SCANNER_CORE_DEFINES_SVH
`define MASKED_BYTE_PATTERN_SCANNER_CORE_DEFINES_SVH

`ifndef SYNTH

// Same-cycle implication
`define MBPS_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define MBPS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`else

`define MBPS_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg)
`define MBPS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

// ===== hdl/mbps_pkg.sv =====
package mbps_pkg;

  // Window depth and the longest usable pattern
  localparam int PATTERN_MAX = 16;
  localparam int LEN_CAP     = (PATTERN_MAX < 16) ? PATTERN_MAX : 16;
  localparam int WIN_IW      = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
  localparam int FIRST_W     = WIN_IW + 1;

  localparam int ADDR_W = 64;
  localparam int LEN_W  = 5;
  localparam int MASK_W = 16;

  // Result queue between scan front and address back end
  localparam int Q_DEPTH = 4;
  localparam int Q_AW    = $clog2(Q_DEPTH);
  localparam int Q_CW    = Q_AW + 1;

  // Configuration register indexes
  localparam int CFG_IW = 3;
  typedef enum logic [CFG_IW-1:0] {
    CFG_PAT_LO     = 3'd0,
    CFG_PAT_HI     = 3'd1,
    CFG_SOLID_MASK = 3'd2,
    CFG_PAT_LEN    = 3'd3,
    CFG_REGION     = 3'd4,
    CFG_FIRST_ONLY = 3'd5
  } cfg_reg_t;

  typedef struct packed {
    logic [63:0]       pat_lo;
    logic [63:0]       pat_hi;
    logic [MASK_W-1:0] solid_mask;
    logic [LEN_W-1:0]  pattern_length;
    logic [ADDR_W-1:0] region_base;
    logic              first_only;
  } cfg_t;

  // One scan result on its way to the queue
  typedef struct packed {
    logic              hit;
    logic [ADDR_W-1:0] offset;
  } scan_res_t;

endpackage

// ===== hdl/mbps_front.sv =====
module mbps_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          take,
  input  logic [7:0]                    data_byte,
  input  logic                          last_byte,
  input  mbps_pkg::cfg_t                cfg,
  output mbps_pkg::scan_res_t           res
);

  logic [7:0]                    win_r   [mbps_pkg::PATTERN_MAX];
  logic [7:0]                    win_nxt [mbps_pkg::PATTERN_MAX];
  logic [7:0]                    sh      [mbps_pkg::PATTERN_MAX];
  logic [63:0]                   seen_r;
  logic [63:0]                   seen_nxt;
  logic [63:0]                   seen_inc;
  logic                          reported_r;
  logic                          reported_nxt;

  logic [mbps_pkg::LEN_W-1:0]    len;
  logic [mbps_pkg::FIRST_W-1:0]  first_full;
  logic [mbps_pkg::WIN_IW-1:0]   first_idx;
  logic [127:0]                  pat_all;
  logic [mbps_pkg::LEN_CAP-1:0]  solid;
  logic [mbps_pkg::LEN_CAP-1:0]  pos_ok;
  logic                          anchor_ok;
  logic                          enough;
  logic                          hit;

  // Window as it stands once the new byte is shifted in
  always_comb begin
    for (int j = 0; j < mbps_pkg::PATTERN_MAX - 1; j++) begin
      sh[j] = win_r[j+1];
    end
    sh[mbps_pkg::PATTERN_MAX-1] = data_byte;
  end

  // Clamp length and locate the first window byte
  always_comb begin
    if (cfg.pattern_length > mbps_pkg::LEN_W'(mbps_pkg::LEN_CAP)) begin
      len = mbps_pkg::LEN_W'(mbps_pkg::LEN_CAP);
    end else begin
      len = cfg.pattern_length;
    end
    first_full = mbps_pkg::FIRST_W'(mbps_pkg::PATTERN_MAX) - mbps_pkg::FIRST_W'(len);
    first_idx  = first_full[mbps_pkg::WIN_IW-1:0];
    pat_all    = {cfg.pat_hi, cfg.pat_lo};
  end

  // Compare every pattern position against its window byte in parallel
  always_comb begin
    logic [mbps_pkg::FIRST_W-1:0] idx;
    for (int k = 0; k < mbps_pkg::LEN_CAP; k++) begin
      idx      = first_full + mbps_pkg::FIRST_W'(k);
      solid[k] = (mbps_pkg::LEN_W'(k) < len) && cfg.solid_mask[k];
      pos_ok[k] = !solid[k] || (sh[idx[mbps_pkg::WIN_IW-1:0]] == pat_all[8*k +: 8]);
    end
  end

  // Anchor applies only when no position is solid
  assign anchor_ok = (|solid) || (sh[first_idx] == 8'h00);
  // Byte count including the new byte, wrapping at 64 bits
  assign seen_inc  = seen_r + 64'd1;
  assign enough    = seen_inc >= 64'(len);

  assign hit = take && (len != '0) && enough && !(cfg.first_only && reported_r)
               && (&pos_ok) && anchor_ok;

  assign res.hit    = hit;
  assign res.offset = seen_inc - 64'(len);

  // Advance window and counters; last byte clears the region
  always_comb begin
    win_nxt      = win_r;
    seen_nxt     = seen_r;
    reported_nxt = reported_r;
    if (take) begin
      if (last_byte) begin
        for (int j = 0; j < mbps_pkg::PATTERN_MAX; j++) begin
          win_nxt[j] = 8'h00;
        end
        seen_nxt     = '0;
        reported_nxt = 1'b0;
      end else begin
        win_nxt      = sh;
        seen_nxt     = seen_inc;
        reported_nxt = reported_r | hit;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int j = 0; j < mbps_pkg::PATTERN_MAX; j++) begin
        win_r[j] <= 8'h00;
      end
      seen_r     <= '0;
      reported_r <= 1'b0;
    end else begin
      win_r      <= win_nxt;
      seen_r     <= seen_nxt;
      reported_r <= reported_nxt;
    end
  end

endmodule

// ===== hdl/mbps_fifo.sv =====
module mbps_fifo (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        push,
  input  logic [mbps_pkg::ADDR_W-1:0] push_data,
  output logic                        full,
  input  logic                        pop,
  output logic                        nonempty,
  output logic [mbps_pkg::ADDR_W-1:0] pop_data
);

  logic [mbps_pkg::ADDR_W-1:0] mem_r [mbps_pkg::Q_DEPTH];
  logic [mbps_pkg::Q_AW-1:0]   wr_ptr_r;
  logic [mbps_pkg::Q_AW-1:0]   wr_ptr_nxt;
  logic [mbps_pkg::Q_AW-1:0]   rd_ptr_r;
  logic [mbps_pkg::Q_AW-1:0]   rd_ptr_nxt;
  logic [mbps_pkg::Q_CW-1:0]   count_r;
  logic [mbps_pkg::Q_CW-1:0]   count_nxt;
  logic                        do_push;
  logic                        do_pop;

  assign full     = count_r == mbps_pkg::Q_CW'(mbps_pkg::Q_DEPTH);
  assign nonempty = count_r != '0;
  assign pop_data = mem_r[rd_ptr_r];
  assign do_push  = push && !full;
  assign do_pop   = pop && nonempty;

  // Advance pointers, wrap at depth
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == mbps_pkg::Q_AW'(mbps_pkg::Q_DEPTH - 1)) ? '0
                   : wr_ptr_r + mbps_pkg::Q_AW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == mbps_pkg::Q_AW'(mbps_pkg::Q_DEPTH - 1)) ? '0
                   : rd_ptr_r + mbps_pkg::Q_AW'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + mbps_pkg::Q_CW'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - mbps_pkg::Q_CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Store the beat payload
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// ===== hdl/mbps_back.sv =====
module mbps_back (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic [mbps_pkg::ADDR_W-1:0] region_base,
  input  logic                        q_nonempty,
  input  logic [mbps_pkg::ADDR_W-1:0] q_data,
  output logic                        q_pop,
  input  logic                        out_pop,
  output logic                        out_empty,
  output logic [mbps_pkg::ADDR_W-1:0] out_match_address
);

  logic                        valid_r;
  logic                        valid_nxt;
  logic [mbps_pkg::ADDR_W-1:0] addr_r;
  logic [mbps_pkg::ADDR_W-1:0] addr_nxt;
  logic                        out_take;
  logic                        load;

  assign out_take = out_pop && valid_r;
  assign load     = q_nonempty && (!valid_r || out_take);
  assign q_pop    = load;

  // Form the region address while refilling the output register
  always_comb begin
    valid_nxt = valid_r;
    addr_nxt  = addr_r;
    if (load) begin
      valid_nxt = 1'b1;
      addr_nxt  = region_base + q_data;
    end else if (out_take) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    addr_r <= addr_nxt;
  end

  assign out_empty         = !valid_r;
  assign out_match_address = addr_r;

endmodule

// ===== hdl/masked_byte_pattern_scanner_core.sv =====
// Masked byte pattern scanner: takes one region byte per clock on the in_
// queue port and compares the last pattern_length bytes (at most 16) against the
// configured pattern (solid positions must match, wildcards pass) all at
// once; on a match it reports region_base plus the offset of the window's
// first byte. The scan accepts a byte every cycle while in_full is low, so
// the sustained rate is one item per clock; a result passes a 4-entry result
// queue and then the output register that adds region_base before it shows
// on the out_ ports. in_full rises only while that queue is full because
// out_pop is held low. cfg_ready is always high;
// write registers only while the block is idle.
`include "masked_byte_pattern_scanner_core_defines.svh"

module masked_byte_pattern_scanner_core (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_push,
  output logic                        in_full,
  input  logic [7:0]                  in_data_byte,
  input  logic                        in_last_byte,
  output logic                        out_empty,
  input  logic                        out_pop,
  output logic [mbps_pkg::ADDR_W-1:0] out_match_address,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [mbps_pkg::CFG_IW-1:0] cfg_index,
  input  logic [63:0]                 cfg_data
);

  mbps_pkg::cfg_t              cfg_r;
  mbps_pkg::cfg_t              cfg_nxt;
  mbps_pkg::scan_res_t         scan_res;
  logic                        take;
  logic                        q_full;
  logic                        q_nonempty;
  logic                        q_pop;
  logic [mbps_pkg::ADDR_W-1:0] q_data;

  assign cfg_ready = 1'b1;
  assign in_full   = q_full;
  assign take      = in_push && !q_full;

  // Decode register writes
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      case (cfg_index)
        mbps_pkg::CFG_PAT_LO:     cfg_nxt.pat_lo         = cfg_data;
        mbps_pkg::CFG_PAT_HI:     cfg_nxt.pat_hi         = cfg_data;
        mbps_pkg::CFG_SOLID_MASK: cfg_nxt.solid_mask     = cfg_data[mbps_pkg::MASK_W-1:0];
        mbps_pkg::CFG_PAT_LEN:    cfg_nxt.pattern_length = cfg_data[mbps_pkg::LEN_W-1:0];
        mbps_pkg::CFG_REGION:     cfg_nxt.region_base    = cfg_data;
        mbps_pkg::CFG_FIRST_ONLY: cfg_nxt.first_only     = cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{pat_lo: '0, pat_hi: '0, solid_mask: '0,
                 pattern_length: mbps_pkg::LEN_W'(1), region_base: '0,
                 first_only: 1'b0};
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  mbps_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .take      (take),
    .data_byte (in_data_byte),
    .last_byte (in_last_byte),
    .cfg       (cfg_r),
    .res       (scan_res)
  );

  mbps_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (scan_res.hit),
    .push_data (scan_res.offset),
    .full      (q_full),
    .pop       (q_pop),
    .nonempty  (q_nonempty),
    .pop_data  (q_data)
  );

  mbps_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .region_base       (cfg_r.region_base),
    .q_nonempty        (q_nonempty),
    .q_data            (q_data),
    .q_pop             (q_pop),
    .out_pop           (out_pop),
    .out_empty         (out_empty),
    .out_match_address (out_match_address)
  );

  // Checks
  `MBPS_ASSERT_IMPL(a_hit_needs_take, clk, rst_n, scan_res.hit, take, "scan hit without an accepted beat")
  `MBPS_ASSERT_IMPL(a_no_push_full, clk, rst_n, scan_res.hit, !q_full, "result pushed into a full queue")
  `MBPS_ASSERT_NEXT(a_refill_out, clk, rst_n, q_nonempty && out_empty, !out_empty, "queued result not moved to output")

endmodule

// ===== test/mbps_match_checker.sv =====
`timescale 1ns / 1ps

module mbps_match_checker (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_push,
  input  logic                        in_full,
  input  logic [7:0]                  in_data_byte,
  input  logic                        in_last_byte,
  input  logic                        out_empty,
  input  logic                        out_pop,
  input  logic [mbps_pkg::ADDR_W-1:0] out_match_address,
  input  logic                        cfg_valid,
  input  logic                        cfg_ready,
  input  logic [mbps_pkg::CFG_IW-1:0] cfg_index,
  input  logic [63:0]                 cfg_data,
  output int                          matches_pending,
  output int                          mismatch_count
);

  // Shadow copy of the configuration registers
  logic [63:0]                 pat_lo;
  logic [63:0]                 pat_hi;
  logic [mbps_pkg::MASK_W-1:0] solid;
  logic [mbps_pkg::LEN_W-1:0]  plen;
  logic [mbps_pkg::ADDR_W-1:0] base;
  logic                        first_only;

  // Shadow copy of the scan state
  logic [7:0]                  window [mbps_pkg::PATTERN_MAX];
  logic [63:0]                 seen;
  logic                        reported;

  // Match addresses predicted but not yet popped
  logic [mbps_pkg::ADDR_W-1:0] match_addr_q [$];
  int                          errors = 0;

  // Compare the newest len bytes against the solid positions of the pattern
  function automatic bit window_hit(int unsigned len);
    int unsigned first;
    int          k;
    bit          any_solid;
    bit          ok;
    logic [127:0] pat;
    first     = mbps_pkg::PATTERN_MAX - len;
    any_solid = 1'b0;
    ok        = 1'b1;
    pat       = {pat_hi, pat_lo};
    for (k = 0; k < len; k++) begin
      if (solid[k]) begin
        any_solid = 1'b1;
        if (window[first + k] != pat[8*k +: 8]) ok = 1'b0;
      end
    end
    // with no solid position the first window byte still has to be zero
    if (!any_solid && window[first] != 8'h00) ok = 1'b0;
    return ok;
  endfunction

  // Advance the shadow state by one byte and queue any match it completes
  function automatic void scan_byte(logic [7:0] b, logic last);
    int unsigned                 len;
    int                          k;
    logic [mbps_pkg::ADDR_W-1:0] addr;
    len = (plen > mbps_pkg::LEN_CAP) ? mbps_pkg::LEN_CAP : plen;
    for (k = 0; k < mbps_pkg::PATTERN_MAX - 1; k++) window[k] = window[k + 1];
    window[mbps_pkg::PATTERN_MAX - 1] = b;
    seen = seen + 64'd1;
    if (len != 0 && seen >= len && !(first_only && reported) && window_hit(len)) begin
      addr         = base + (seen - 64'(len));
      match_addr_q = {match_addr_q, addr};
      reported     = 1'b1;
    end
    // the last byte of a region clears the counters and the window
    if (last) begin
      seen     = '0;
      reported = 1'b0;
      for (k = 0; k < mbps_pkg::PATTERN_MAX; k++) window[k] = 8'h00;
    end
  endfunction

  always @(posedge clk) begin
    logic [mbps_pkg::ADDR_W-1:0] want;
    if (!rst_n) begin
      pat_lo     = '0;
      pat_hi     = '0;
      solid      = '0;
      plen       = mbps_pkg::LEN_W'(1);
      base       = '0;
      first_only = 1'b0;
      seen       = '0;
      reported   = 1'b0;
      for (int k = 0; k < mbps_pkg::PATTERN_MAX; k++) window[k] = 8'h00;
      match_addr_q.delete();
    end else begin
      // register writes
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          mbps_pkg::CFG_PAT_LO:     pat_lo     = cfg_data;
          mbps_pkg::CFG_PAT_HI:     pat_hi     = cfg_data;
          mbps_pkg::CFG_SOLID_MASK: solid      = cfg_data[mbps_pkg::MASK_W-1:0];
          mbps_pkg::CFG_PAT_LEN:    plen       = cfg_data[mbps_pkg::LEN_W-1:0];
          mbps_pkg::CFG_REGION:     base       = cfg_data;
          mbps_pkg::CFG_FIRST_ONLY: first_only = cfg_data[0];
          default: ;
        endcase
      end
      // check a popped result beat against the oldest prediction
      if (out_pop && !out_empty) begin
        if (match_addr_q.size() == 0) begin
          $display("%0t: match_address expected none, actual %h", $time,
                   out_match_address);
          errors++;
        end else begin
          want = match_addr_q.pop_front();
          if (want !== out_match_address) begin
            $display("%0t: match_address expected %h, actual %h", $time, want,
                     out_match_address);
            errors++;
          end
        end
      end
      // predict from an accepted byte beat
      if (in_push && !in_full) scan_byte(in_data_byte, in_last_byte);
    end
    matches_pending <= match_addr_q.size();
    mismatch_count  <= errors;
  end

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;

  localparam int LIMIT = 400000;
  localparam int RANDOM_BYTES = 1300;
  localparam int CALM_FROM = 1150;
  localparam logic [mbps_pkg::CFG_IW-1:0] CFG_SPARE_LO = 3'd6;
  localparam logic [mbps_pkg::CFG_IW-1:0] CFG_SPARE_HI = 3'd7;

  logic                        clk = 1'b0;
  logic                        rst_n = 1'b0;
  logic                        in_push = 1'b0;
  logic                        in_full;
  logic [7:0]                  in_data_byte = 8'h00;
  logic                        in_last_byte = 1'b0;
  logic                        out_empty;
  logic                        out_pop = 1'b0;
  logic [mbps_pkg::ADDR_W-1:0] out_match_address;
  logic                        cfg_valid = 1'b0;
  logic                        cfg_ready;
  logic [mbps_pkg::CFG_IW-1:0] cfg_index = '0;
  logic [63:0]                 cfg_data = '0;

  int matches_pending;
  int mismatch_count;
  int cycle_count = 0;

  // Stimulus knobs shared with the pop side
  bit gaps_on = 1'b1;
  bit pop_stalls_on = 1'b1;
  bit calm = 1'b0;

  // Configuration currently programmed
  logic [63:0]                 cur_pat_lo;
  logic [63:0]                 cur_pat_hi;
  logic [mbps_pkg::MASK_W-1:0] cur_mask;
  logic [mbps_pkg::LEN_W-1:0]  cur_len;
  logic [mbps_pkg::ADDR_W-1:0] cur_base;
  logic                        cur_first;

  masked_byte_pattern_scanner_core dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_push          (in_push),
    .in_full          (in_full),
    .in_data_byte     (in_data_byte),
    .in_last_byte     (in_last_byte),
    .out_empty        (out_empty),
    .out_pop          (out_pop),
    .out_match_address(out_match_address),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  mbps_match_checker u_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_push          (in_push),
    .in_full          (in_full),
    .in_data_byte     (in_data_byte),
    .in_last_byte     (in_last_byte),
    .out_empty        (out_empty),
    .out_pop          (out_pop),
    .out_match_address(out_match_address),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .matches_pending  (matches_pending),
    .mismatch_count   (mismatch_count)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Bound the run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT) begin
      $display("%0t: timeout, %0d matches still pending", $time, matches_pending);
      $display("Verification failed");
      $finish;
    end
  end

  // Result side: pop with random stall bursts
  initial begin
    forever begin
      @(posedge clk);
      if (!calm && pop_stalls_on && $urandom_range(0, 5) == 0) begin
        out_pop <= 1'b0;
        repeat ($urandom_range(1, 18)) @(posedge clk);
      end
      out_pop <= 1'b1;
    end
  end

  function automatic logic [7:0] pat_byte(int k);
    logic [127:0] pat;
    pat = {cur_pat_hi, cur_pat_lo};
    return pat[8*k +: 8];
  endfunction

  function automatic int eff_len();
    return (cur_len > mbps_pkg::LEN_CAP) ? mbps_pkg::LEN_CAP : int'(cur_len);
  endfunction

  // Hold one config beat until the channel takes it
  task automatic write_reg(input logic [mbps_pkg::CFG_IW-1:0] idx, input logic [63:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // Program every register from the cur_ copies, optionally poking spare indexes
  task automatic write_all(input bit spare);
    write_reg(mbps_pkg::CFG_PAT_LO, cur_pat_lo);
    if (spare) write_reg(CFG_SPARE_LO, {$urandom, $urandom});
    write_reg(mbps_pkg::CFG_PAT_HI, cur_pat_hi);
    write_reg(mbps_pkg::CFG_SOLID_MASK, 64'(cur_mask));
    write_reg(mbps_pkg::CFG_PAT_LEN, 64'(cur_len));
    if (spare) write_reg(CFG_SPARE_HI, {$urandom, $urandom});
    write_reg(mbps_pkg::CFG_REGION, cur_base);
    write_reg(mbps_pkg::CFG_FIRST_ONLY, 64'(cur_first));
    cfg_valid <= 1'b0;
  endtask

  // Hold one byte beat until accepted, then maybe pause
  task automatic send_byte(input logic [7:0] b, input logic last);
    in_push      <= 1'b1;
    in_data_byte <= b;
    in_last_byte <= last;
    do @(posedge clk); while (in_full);
    if (!calm && gaps_on && $urandom_range(0, 7) == 0) begin
      in_push <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
  endtask

  // Stop sending and drain every predicted match, then let the pipe empty
  task automatic drain();
    in_push <= 1'b0;
    repeat (2) @(posedge clk);
    while (matches_pending != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  // Pick a configuration; the first few phases pin the extremes
  task automatic pick_config(input int phase);
    case (phase)
      0: begin
        cur_pat_lo = '1; cur_pat_hi = '1; cur_mask = '1;
        cur_len = mbps_pkg::LEN_W'(16); cur_base = '1; cur_first = 1'b0;
      end
      1: begin
        cur_pat_lo = '0; cur_pat_hi = '0; cur_mask = '0;
        cur_len = mbps_pkg::LEN_W'(31); cur_base = '0; cur_first = 1'b1;
      end
      2: begin
        cur_pat_lo = {$urandom, $urandom}; cur_pat_hi = {$urandom, $urandom};
        cur_mask = '1; cur_len = mbps_pkg::LEN_W'(17); cur_base = {$urandom, $urandom};
        cur_first = 1'b0;
      end
      3: begin
        // dense matches to back up the result queue
        cur_pat_lo = '0; cur_pat_hi = '0; cur_mask = mbps_pkg::MASK_W'(1);
        cur_len = mbps_pkg::LEN_W'(1); cur_base = ~64'd3; cur_first = 1'b0;
      end
      default: begin
        cur_pat_lo = {$urandom, $urandom};
        cur_pat_hi = {$urandom, $urandom};
        case ($urandom_range(0, 4))
          0: cur_mask = '0;
          1: cur_mask = '1;
          2, 3: cur_mask = mbps_pkg::MASK_W'($urandom);
          default: cur_mask = mbps_pkg::MASK_W'(1) << $urandom_range(0, mbps_pkg::MASK_W - 1);
        endcase
        case ($urandom_range(0, 9))
          0: cur_len = '0;
          1: cur_len = mbps_pkg::LEN_W'($urandom_range(17, 31));
          default: cur_len = mbps_pkg::LEN_W'($urandom_range(1, 16));
        endcase
        if ($urandom_range(0, 3) == 0) cur_base = ~64'd0 - 64'($urandom_range(0, 40));
        else cur_base = {$urandom, $urandom};
        cur_first = 1'($urandom_range(0, 1));
      end
    endcase
  endtask

  initial begin
    int          phase;
    int          sent;
    int          beats;
    int          plant_left;
    int          len;
    int          k;
    bit          no_solid;
    logic [7:0]  b;
    logic        last;

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset config: no solid byte, so only a zero first byte matches
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b1);
    drain();

    // Four-byte pattern with a wildcard; base near the top so addresses wrap
    cur_pat_lo = 64'h0000_0000_DDCC_BBAA;
    cur_pat_hi = 64'h8000_0000_0000_0001;
    cur_mask   = mbps_pkg::MASK_W'(16'h000D);
    cur_len    = mbps_pkg::LEN_W'(4);
    cur_base   = 64'hFFFF_FFFF_FFFF_FFFE;
    cur_first  = 1'b0;
    write_all(1'b1);
    send_byte(8'hAA, 1'b0);
    send_byte(8'h55, 1'b0);
    send_byte(8'hCC, 1'b0);
    send_byte(8'hDD, 1'b0);
    send_byte(8'hAA, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'hCC, 1'b0);
    send_byte(8'hDD, 1'b0);
    send_byte(8'h01, 1'b1);
    drain();

    // First-only: the second occurrence gives nothing
    cur_first = 1'b1;
    write_all(1'b0);
    send_byte(8'hAA, 1'b0);
    send_byte(8'h11, 1'b0);
    send_byte(8'hCC, 1'b0);
    send_byte(8'hDD, 1'b0);
    send_byte(8'hAA, 1'b0);
    send_byte(8'h22, 1'b0);
    send_byte(8'hCC, 1'b0);
    send_byte(8'hDD, 1'b1);
    drain();

    // Zero length never matches
    cur_len = '0;
    write_all(1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b1);
    drain();

    // Random phases: noise plus planted pattern occurrences
    phase = 0;
    sent  = 0;
    while (sent < RANDOM_BYTES) begin
      pick_config(phase);
      write_all($urandom_range(0, 3) == 0);
      if (sent >= CALM_FROM) calm = 1'b1;
      gaps_on       = ($urandom_range(0, 2) != 0);
      pop_stalls_on = ($urandom_range(0, 2) != 0);
      len      = eff_len();
      no_solid = 1'b1;
      for (k = 0; k < len; k++) if (cur_mask[k]) no_solid = 1'b0;
      plant_left = 0;
      beats = $urandom_range(30, 90);
      repeat (beats) begin
        if (plant_left == 0 && len != 0 && $urandom_range(0, 6) == 0) plant_left = len;
        if (plant_left > 0) begin
          k = len - plant_left;
          if (cur_mask[k]) b = pat_byte(k);
          else if (no_solid && k == 0) b = 8'h00;
          else b = 8'($urandom);
          plant_left--;
        end else if ($urandom_range(0, 1) == 0) begin
          b = pat_byte($urandom_range(0, 15));
        end else begin
          b = 8'($urandom);
        end
        last = ($urandom_range(0, 39) == 0);
        if (last) plant_left = 0;
        send_byte(b, last);
        sent++;
      end
      drain();
      phase++;
    end

    if (mismatch_count == 0 && matches_pending == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ===== masked_byte_pattern_scanner_core.f =====
+incdir+hdl
hdl/mbps_pkg.sv
hdl/mbps_front.sv
hdl/mbps_fifo.sv
hdl/mbps_back.sv
hdl/masked_byte_pattern_scanner_core.sv
test/mbps_match_checker.sv
test/tb_top.sv
